>>> hw/rtl/arpc_pkg.sv
// Shared types, codes and constants of the ARP responder and address cache.
package arpc_pkg;

    localparam int ARPC_CACHE_ENTRIES = 128;

    // Payload widths of the stream channels.
    localparam int S_TDATA_W = 184;
    localparam int S_TUSER_W = 1;
    localparam int M_TDATA_W = 80;
    localparam int KIND_W    = 3;

    // Configuration port.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 48;
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_IP  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_MAC = 1'b1;

    // Item commands carried in s_tuser.
    localparam logic CMD_MESSAGE = 1'b0;
    localparam logic CMD_LOOKUP  = 1'b1;

    // Result kinds carried in m_tuser.
    localparam logic [KIND_W-1:0] KIND_DROP   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_REPLY  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_CACHED = 3'd2;
    localparam logic [KIND_W-1:0] KIND_HIT    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_MISS   = 3'd4;

    // ARP header values that a valid message must carry.
    localparam logic [15:0] HTYPE_ETH   = 16'h0001;
    localparam logic [15:0] PTYPE_IPV4  = 16'h0800;
    localparam logic [7:0]  HLEN_ETH    = 8'd6;
    localparam logic [7:0]  PLEN_IPV4   = 8'd4;
    localparam logic [15:0] OP_REQUEST  = 16'd1;
    localparam logic [15:0] OP_RESPONSE = 16'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic              load;
        logic              scan_start;
        logic              scan_en;
        logic              insert;
        logic              out_load;
        logic [KIND_W-1:0] out_kind;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_lookup;
        logic msg_ok;
        logic op_request;
        logic op_response;
        logic scan_hit;
        logic scan_end;
        logic out_free;
    } sts_t;

endpackage

>>> hw/rtl/arp_responder_and_cache.sv
// Top level of the ARP responder with address cache.
// ARP offload engine: each accepted item gives exactly one result item. A received
// message (s_tuser = 0) is checked and gives a reply order, a learned-or-known report
// or a drop; a lookup (s_tuser = 1) searches the cache by IP and returns the MAC, or
// all ones on a miss. The cache holds CACHE_ENTRIES entries in on-chip memory, filled
// round-robin; a fill count stands for the all-ones reset value, so no clearing pass
// is needed. One item is worked on at a time. A lookup or a valid response scans the
// cache through its single read port, one entry per cycle, stopping at the first match.
// A request, a drop or an unknown opcode skips the scan and goes from classification
// straight to the result. A new item is accepted while the previous result still
// waits on the output.
module arp_responder_and_cache #(
    parameter int CACHE_ENTRIES = arpc_pkg::ARPC_CACHE_ENTRIES
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Input items.
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // htype[15:0], protocol_type[31:16], hw_addr_len[39:32],
    // proto_addr_len[47:40], opcode[63:48], sender_mac[111:64], sender_ip[143:112],
    // target_ip[175:144], length_ok[176], zero fill[183:177]
    input  logic [arpc_pkg::S_TDATA_W-1:0]  s_tdata,
    // command[0]
    input  logic [arpc_pkg::S_TUSER_W-1:0]  s_tuser,
    // Result items.
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // peer_mac[47:0], peer_ip[79:48]
    output logic [arpc_pkg::M_TDATA_W-1:0]  m_tdata,
    // result_kind[2:0]
    output logic [arpc_pkg::KIND_W-1:0]     m_tuser,
    // Configuration: index 0 own_ip, index 1 own_mac.
    input  logic                            cfg_wr_en,
    input  logic [arpc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [arpc_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import arpc_pkg::*;

    cmd_t cmd;
    sts_t sts;

    arpc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    arpc_dp #(
        .CACHE_ENTRIES (CACHE_ENTRIES)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

>>> hw/rtl/arpc_dp.sv
// Datapath: item registers, configuration, address cache with scan, and result register.
module arpc_dp #(
    parameter int CACHE_ENTRIES = arpc_pkg::ARPC_CACHE_ENTRIES
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  arpc_pkg::cmd_t                  cmd,
    output arpc_pkg::sts_t                  sts,
    input  logic [arpc_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic [arpc_pkg::S_TUSER_W-1:0]  s_tuser,
    input  logic                            cfg_wr_en,
    input  logic [arpc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [arpc_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [arpc_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic [arpc_pkg::KIND_W-1:0]     m_tuser
);
    import arpc_pkg::*;

    localparam int IDX_W  = $clog2(CACHE_ENTRIES);
    localparam int FILL_W = $clog2(CACHE_ENTRIES + 1);
    localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(CACHE_ENTRIES - 1);
    localparam logic [FILL_W-1:0] FULL_CNT = FILL_W'(CACHE_ENTRIES);

    // Captured item.
    logic        command_reg;
    logic [15:0] htype_reg;
    logic [15:0] ptype_reg;
    logic [7:0]  hlen_reg;
    logic [7:0]  plen_reg;
    logic [15:0] opcode_reg;
    logic [47:0] smac_reg;
    logic [31:0] sip_reg;
    logic [31:0] tip_reg;
    logic        len_ok_reg;

    logic [31:0] own_ip_reg;
    logic [47:0] own_mac_reg;

    // Cache storage; entries at or above the fill count were never written.
    logic [31:0] ip_mem  [CACHE_ENTRIES];
    logic [47:0] mac_mem [CACHE_ENTRIES];
    logic [IDX_W-1:0]  ptr_reg;
    logic [FILL_W-1:0] fill_reg;

    // Scan pipeline: read address, then registered read data under compare.
    logic [IDX_W-1:0] rd_idx_reg;
    logic [IDX_W-1:0] cmp_idx_reg;
    logic             cmp_vld_reg;
    logic [31:0]      ip_q_reg;
    logic [47:0]      mac_q_reg;

    logic              out_vld_reg;
    logic [KIND_W-1:0] out_kind_reg;
    logic [47:0]       out_mac_reg;
    logic [31:0]       out_ip_reg;

    logic        entry_valid;
    logic [31:0] eff_ip;
    logic [47:0] eff_mac;
    logic [31:0] key_ip;
    logic        match;
    logic [47:0] res_mac;
    logic [31:0] res_ip;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            command_reg <= s_tuser[0];
            htype_reg   <= s_tdata[15:0];
            ptype_reg   <= s_tdata[31:16];
            hlen_reg    <= s_tdata[39:32];
            plen_reg    <= s_tdata[47:40];
            opcode_reg  <= s_tdata[63:48];
            smac_reg    <= s_tdata[111:64];
            sip_reg     <= s_tdata[143:112];
            tip_reg     <= s_tdata[175:144];
            len_ok_reg  <= s_tdata[176];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            own_ip_reg  <= '0;
            own_mac_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_OWN_IP:  own_ip_reg  <= cfg_wdata[31:0];
                CFG_OWN_MAC: own_mac_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.insert) begin
            ip_mem[ptr_reg]  <= sip_reg;
            mac_mem[ptr_reg] <= smac_reg;
        end
        if (cmd.scan_en) begin
            ip_q_reg  <= ip_mem[rd_idx_reg];
            mac_q_reg <= mac_mem[rd_idx_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ptr_reg  <= '0;
            fill_reg <= '0;
        end else if (cmd.insert) begin
            ptr_reg <= (ptr_reg == LAST_IDX) ? '0 : ptr_reg + 1'b1;
            if (fill_reg != FULL_CNT) begin
                fill_reg <= fill_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_idx_reg  <= '0;
            cmp_idx_reg <= '0;
            cmp_vld_reg <= 1'b0;
        end else if (cmd.scan_start) begin
            rd_idx_reg  <= '0;
            cmp_vld_reg <= 1'b0;
        end else if (cmd.scan_en) begin
            rd_idx_reg  <= (rd_idx_reg == LAST_IDX) ? '0 : rd_idx_reg + 1'b1;
            cmp_idx_reg <= rd_idx_reg;
            cmp_vld_reg <= 1'b1;
        end
    end

    // An unwritten entry reads as its reset value, all ones.
    assign entry_valid = FILL_W'(cmp_idx_reg) < fill_reg;
    assign eff_ip      = entry_valid ? ip_q_reg  : '1;
    assign eff_mac     = entry_valid ? mac_q_reg : '1;
    assign key_ip      = (command_reg == CMD_LOOKUP) ? tip_reg : sip_reg;
    assign match       = cmp_vld_reg && (eff_ip == key_ip);

    assign sts.is_lookup   = (command_reg == CMD_LOOKUP);
    assign sts.msg_ok      = len_ok_reg && (htype_reg == HTYPE_ETH) &&
                             (ptype_reg == PTYPE_IPV4) && (hlen_reg == HLEN_ETH) &&
                             (plen_reg == PLEN_IPV4) && (tip_reg == own_ip_reg);
    assign sts.op_request  = (opcode_reg == OP_REQUEST);
    assign sts.op_response = (opcode_reg == OP_RESPONSE);
    assign sts.scan_hit    = match;
    assign sts.scan_end    = cmp_vld_reg && !match && (cmp_idx_reg == LAST_IDX);
    assign sts.out_free    = !out_vld_reg || m_tready;

    // The compare stage is frozen once the scan stops, so eff_mac still holds the hit.
    always_comb begin
        case (cmd.out_kind)
            KIND_REPLY, KIND_CACHED: begin
                res_mac = smac_reg;
                res_ip  = sip_reg;
            end
            KIND_HIT: begin
                res_mac = eff_mac;
                res_ip  = tip_reg;
            end
            KIND_MISS: begin
                res_mac = '1;
                res_ip  = tip_reg;
            end
            default: begin
                res_mac = '0;
                res_ip  = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_vld_reg <= 1'b1;
        end else if (m_tready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_kind_reg <= cmd.out_kind;
            out_mac_reg  <= res_mac;
            out_ip_reg   <= res_ip;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = {out_ip_reg, out_mac_reg};

    // The own MAC is the reply source; the reply frame is built outside this block.
    logic unused_own_mac;
    assign unused_own_mac = ^own_mac_reg;

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FULL_CNT)
        else $error("cache fill count beyond the number of entries");

    a_ptr_follows_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        (fill_reg != FULL_CNT) |-> (FILL_W'(ptr_reg) == fill_reg))
        else $error("insert pointer out of step with fill count before wrap");

endmodule

>>> hw/rtl/arpc_ctrl.sv
// Controller: sequences accept, classify, cache scan, insertion and result hand-off.
module arpc_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  arpc_pkg::sts_t sts,
    output arpc_pkg::cmd_t cmd
);
    import arpc_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_DECIDE = 2'd1;
    localparam logic [1:0] ST_SCAN   = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [KIND_W-1:0] kind_reg, kind_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            kind_reg  <= KIND_DROP;
        end else begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        cmd.load       = 1'b0;
        cmd.scan_start = 1'b0;
        cmd.scan_en    = 1'b0;
        cmd.insert     = 1'b0;
        cmd.out_load   = 1'b0;
        cmd.out_kind   = kind_reg;
        s_tready       = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (sts.is_lookup || (sts.msg_ok && sts.op_response)) begin
                    cmd.scan_start = 1'b1;
                    state_next     = ST_SCAN;
                end else begin
                    kind_next  = (sts.msg_ok && sts.op_request) ? KIND_REPLY : KIND_DROP;
                    state_next = ST_FINISH;
                end
            end
            ST_SCAN: begin
                if (sts.scan_hit) begin
                    kind_next  = sts.is_lookup ? KIND_HIT : KIND_CACHED;
                    state_next = ST_FINISH;
                end else if (sts.scan_end) begin
                    // A new sender address is learned into the next round-robin slot.
                    cmd.insert = !sts.is_lookup;
                    kind_next  = sts.is_lookup ? KIND_MISS : KIND_CACHED;
                    state_next = ST_FINISH;
                end else begin
                    cmd.scan_en = 1'b1;
                end
            end
            ST_FINISH: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_out_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> sts.out_free)
        else $error("result loaded while the output register is occupied");

    a_insert_on_miss: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.insert |-> (sts.scan_end && !sts.scan_hit && !sts.is_lookup))
        else $error("cache insert without a completed missing scan");

    a_single_result: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |=> (state_reg == ST_IDLE))
        else $error("controller did not return to idle after a result");

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the ARP responder and address cache.
module tb;
    import arpc_pkg::*;

    localparam int          CLK_HALF     = 10;
    localparam int          CACHE_N      = ARPC_CACHE_ENTRIES;
    localparam int          POOL_N       = 180;
    localparam int          PHASES       = 6;
    localparam int          PHASE_ITEMS  = 300;
    localparam int          HOLD_CYCLES  = 400;
    localparam int          HOLD_ITEMS   = 8;
    localparam int          TAIL_CYCLES  = 160;
    localparam int          CYCLE_LIMIT  = 1200000;
    localparam logic [47:0] MAC_ONES     = '1;
    localparam logic [31:0] IP_ONES      = '1;

    typedef struct packed {
        logic        cmd;
        logic [15:0] htype;
        logic [15:0] ptype;
        logic [7:0]  hlen;
        logic [7:0]  plen;
        logic [15:0] op;
        logic [47:0] smac;
        logic [31:0] sip;
        logic [31:0] tip;
        logic        len_ok;
    } arp_msg_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [47:0]       mac;
        logic [31:0]       ip;
    } arp_outcome_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic [S_TUSER_W-1:0]  s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [KIND_W-1:0]     m_tuser;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // Predicted state of the block.
    logic [31:0]  model_own_ip;
    logic [47:0]  model_own_mac;
    logic [31:0]  cache_ip  [CACHE_N];
    logic [47:0]  cache_mac [CACHE_N];
    int unsigned  cache_next;

    arp_outcome_t pending_outcomes[$];
    logic [31:0]  ip_pool [POOL_N];
    int           fail_count = 0;
    bit           src_idle   = 1'b0;
    bit           sink_idle  = 1'b0;
    int           hold_seq   = 0;
    int           hold_done  = 0;
    int           sink_hold  = 0;
    int           sink_wait  = 0;

    arp_responder_and_cache dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #CLK_HALF aclk = 1'b1;
        #CLK_HALF aclk = 1'b0;
    end

    initial begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("tb: errors");
        $finish;
    end

    function automatic void flag_error(string what);
        fail_count++;
        if (fail_count <= 10) $display("mismatch: %s", what);
    endfunction

    function automatic logic [47:0] rand_mac();
        logic [63:0] raw;
        raw = {$urandom(), $urandom()};
        return raw[47:0];
    endfunction

    function automatic arp_outcome_t outcome(logic [KIND_W-1:0] kind, logic [47:0] mac,
                                             logic [31:0] ip);
        arp_outcome_t r;
        r.kind = kind;
        r.mac  = mac;
        r.ip   = ip;
        return r;
    endfunction

    // Lowest index holding ip, as the hardware scan stops at the first match.
    function automatic int cache_find(logic [31:0] ip);
        for (int i = 0; i < CACHE_N; i++)
            if (cache_ip[i] == ip) return i;
        return -1;
    endfunction

    function automatic arp_outcome_t arp_outcome(arp_msg_t m);
        arp_outcome_t r;
        int           slot;
        r = outcome(KIND_DROP, 48'd0, 32'd0);
        if (m.cmd == CMD_LOOKUP) begin
            slot = cache_find(m.tip);
            if (slot >= 0) r = outcome(KIND_HIT, cache_mac[slot], m.tip);
            else r = outcome(KIND_MISS, MAC_ONES, m.tip);
        end else if (m.len_ok && m.htype == HTYPE_ETH && m.ptype == PTYPE_IPV4 &&
                     m.hlen == HLEN_ETH && m.plen == PLEN_IPV4 && m.tip == model_own_ip) begin
            if (m.op == OP_REQUEST) begin
                r = outcome(KIND_REPLY, m.smac, m.sip);
            end else if (m.op == OP_RESPONSE) begin
                if (cache_find(m.sip) < 0) begin
                    cache_ip[cache_next]  = m.sip;
                    cache_mac[cache_next] = m.smac;
                    cache_next = (cache_next + 1) % CACHE_N;
                end
                r = outcome(KIND_CACHED, m.smac, m.sip);
            end
        end
        return r;
    endfunction

    function automatic arp_msg_t lookup_msg(logic [31:0] ip);
        arp_msg_t m;
        // The message fields carry noise; a lookup must ignore them.
        m.cmd    = CMD_LOOKUP;
        m.htype  = 16'($urandom());
        m.ptype  = 16'($urandom());
        m.hlen   = 8'($urandom());
        m.plen   = 8'($urandom());
        m.op     = 16'($urandom());
        m.smac   = rand_mac();
        m.sip    = $urandom();
        m.tip    = ip;
        m.len_ok = 1'($urandom());
        return m;
    endfunction

    function automatic arp_msg_t good_msg(logic [15:0] op, logic [47:0] smac, logic [31:0] sip);
        arp_msg_t m;
        m.cmd    = CMD_MESSAGE;
        m.htype  = HTYPE_ETH;
        m.ptype  = PTYPE_IPV4;
        m.hlen   = HLEN_ETH;
        m.plen   = PLEN_IPV4;
        m.op     = op;
        m.smac   = smac;
        m.sip    = sip;
        m.tip    = model_own_ip;
        m.len_ok = 1'b1;
        return m;
    endfunction

    function automatic logic [31:0] pick_ip();
        int r;
        r = $urandom_range(0, 99);
        if (r < 6) return IP_ONES;
        if (r < 88) return ip_pool[$urandom_range(0, POOL_N - 1)];
        return $urandom();
    endfunction

    function automatic arp_msg_t random_msg();
        arp_msg_t    m;
        int          pick;
        int          r;
        logic [15:0] op;
        logic [47:0] smac;
        pick = $urandom_range(0, 99);
        if (pick < 25) return lookup_msg(pick_ip());
        r = $urandom_range(0, 19);
        if (r < 9) op = OP_REQUEST;
        else if (r < 19) op = OP_RESPONSE;
        else op = 16'($urandom());
        r = $urandom_range(0, 19);
        if (r == 0) smac = 48'd0;
        else if (r == 1) smac = MAC_ONES;
        else smac = rand_mac();
        m = good_msg(op, smac, pick_ip());
        // A share of messages gets one or two broken fields, or is noise throughout.
        if (pick >= 85) begin
            case ($urandom_range(0, 7))
                0: m.len_ok = 1'b0;
                1: m.htype  = 16'($urandom());
                2: m.ptype  = 16'($urandom());
                3: m.hlen   = 8'($urandom());
                4: m.plen   = 8'($urandom());
                5: m.tip    = $urandom();
                6: begin
                    m = lookup_msg($urandom());
                    m.cmd = CMD_MESSAGE;
                end
                default: begin
                    m.htype = 16'h0100;
                    m.ptype = 16'h0008;
                end
            endcase
        end
        return m;
    endfunction

    task automatic send_item(arp_msg_t m);
        int gap;
        gap = (src_idle && $urandom_range(0, 4) == 0) ? $urandom_range(1, 11) : 0;
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, m.len_ok, m.tip, m.sip, m.smac, m.op, m.plen, m.hlen,
                     m.ptype, m.htype};
        s_tuser  <= m.cmd;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_outcomes.push_back(arp_outcome(m));
    endtask

    task automatic stop_and_drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_outcomes.size() != 0) @(posedge aclk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == CFG_OWN_IP) model_own_ip = value[31:0];
        else model_own_mac = value;
    endtask

    task automatic test_directed();
        arp_msg_t    m;
        logic [31:0] ip_a;
        logic [31:0] ip_b;
        logic [47:0] mac_a;
        ip_a  = 32'h0A00_0005;
        ip_b  = 32'h0A00_0006;
        mac_a = 48'h0200_1234_5678;
        // Own IP still holds its reset value of zero.
        send_item(good_msg(OP_REQUEST, rand_mac(), 32'hC0A8_0102));
        stop_and_drain();
        cfg_write(CFG_OWN_IP, 48'h0000_C0A8_0001);
        cfg_write(CFG_OWN_MAC, 48'h0200_0000_0001);

        // An empty entry holds all ones, so that address hits.
        send_item(lookup_msg(IP_ONES));
        send_item(lookup_msg(32'd0));
        send_item(good_msg(OP_REQUEST, MAC_ONES, 32'd0));
        send_item(good_msg(OP_REQUEST, 48'd0, IP_ONES));

        m = good_msg(OP_REQUEST, rand_mac(), ip_a);
        m.len_ok = 1'b0;
        send_item(m);
        m = good_msg(OP_REQUEST, rand_mac(), ip_a);
        m.htype = 16'h0100;
        send_item(m);
        m = good_msg(OP_REQUEST, rand_mac(), ip_a);
        m.ptype = 16'h0008;
        send_item(m);
        m = good_msg(OP_REQUEST, rand_mac(), ip_a);
        m.hlen = 8'd5;
        send_item(m);
        m = good_msg(OP_REQUEST, rand_mac(), ip_a);
        m.plen = 8'hFF;
        send_item(m);
        m = good_msg(OP_RESPONSE, rand_mac(), ip_a);
        m.tip = model_own_ip ^ 32'd1;
        send_item(m);

        // Unknown opcodes on otherwise valid messages are dropped.
        send_item(good_msg(16'd0, rand_mac(), ip_a));
        send_item(good_msg(16'd3, rand_mac(), ip_a));
        send_item(good_msg(16'hFFFF, rand_mac(), ip_a));

        send_item(good_msg(OP_RESPONSE, mac_a, ip_a));
        // Already known: the cache keeps the first MAC.
        send_item(good_msg(OP_RESPONSE, rand_mac(), ip_a));
        send_item(lookup_msg(ip_a));
        send_item(good_msg(OP_RESPONSE, rand_mac(), IP_ONES));
        send_item(lookup_msg(IP_ONES));
        send_item(good_msg(OP_RESPONSE, rand_mac(), ip_b));
        send_item(lookup_msg(IP_ONES));
        send_item(lookup_msg(ip_b));
        stop_and_drain();
    endtask

    task automatic test_backpressure();
        @(posedge aclk);
        hold_seq = hold_seq + 1;
        repeat (HOLD_ITEMS) send_item(random_msg());
        stop_and_drain();
    endtask

    task automatic test_random_phases();
        for (int p = 0; p < PHASES; p++) begin
            stop_and_drain();
            case (p)
                1: begin
                    cfg_write(CFG_OWN_IP, '0);
                    cfg_write(CFG_OWN_MAC, '0);
                end
                2: begin
                    cfg_write(CFG_OWN_IP, {16'd0, IP_ONES});
                    cfg_write(CFG_OWN_MAC, MAC_ONES);
                end
                default: begin
                    cfg_write(CFG_OWN_IP, {16'd0, 32'($urandom())});
                    cfg_write(CFG_OWN_MAC, rand_mac());
                end
            endcase
            // The final phase runs without idling on either side.
            src_idle  = (p != 2) && (p != PHASES - 1);
            sink_idle = (p != 3) && (p != PHASES - 1);
            repeat (PHASE_ITEMS) send_item(random_msg());
        end
        stop_and_drain();
    endtask

    // Result side: random stall bursts, plus a long hold-off on request.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_seq != hold_done) begin
            m_tready <= 1'b0;
            if (sink_hold == HOLD_CYCLES - 1) begin
                sink_hold <= 0;
                hold_done <= hold_seq;
            end else begin
                sink_hold <= sink_hold + 1;
            end
        end else if (sink_wait > 0) begin
            m_tready  <= 1'b0;
            sink_wait <= sink_wait - 1;
        end else if (sink_idle && $urandom_range(0, 5) == 0) begin
            m_tready  <= 1'b0;
            sink_wait <= $urandom_range(0, 10);
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin : check_result
        arp_outcome_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_outcomes.size() == 0) begin
                flag_error($sformatf("unexpected result kind %0d data %h", m_tuser, m_tdata));
            end else begin
                want = pending_outcomes.pop_front();
                if (m_tuser !== want.kind || m_tdata[47:0] !== want.mac ||
                    m_tdata[79:48] !== want.ip)
                    flag_error($sformatf(
                        "kind exp %0d got %0d, mac exp %h got %h, ip exp %h got %h",
                        want.kind, m_tuser, want.mac, m_tdata[47:0], want.ip,
                        m_tdata[79:48]));
            end
        end
    end

    initial begin
        for (int i = 0; i < CACHE_N; i++) begin
            cache_ip[i]  = IP_ONES;
            cache_mac[i] = MAC_ONES;
        end
        cache_next    = 0;
        model_own_ip  = '0;
        model_own_mac = '0;
        for (int i = 0; i < POOL_N; i++) ip_pool[i] = $urandom();
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        src_idle  = 1'b1;
        sink_idle = 1'b1;
        test_directed();
        test_backpressure();
        test_random_phases();

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (pending_outcomes.size() != 0)
            flag_error($sformatf("%0d results never arrived", pending_outcomes.size()));
        if (fail_count == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/arpc_pkg.sv
hw/rtl/arpc_dp.sv
hw/rtl/arpc_ctrl.sv
hw/rtl/arp_responder_and_cache.sv
tb/tb.sv
